// ===== hw/rtl/rspt_pkg.sv =====
// Shared types and constants of the route size predictor table.
package rspt_pkg;

	localparam int ROUTE_ENTRIES = 64;
	localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

	localparam logic [31:0] MIN_PREDICTION = 32'd4096;
	localparam logic [6:0] PERCENT_FULL = 7'd100;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	// floor(x / 100) = (x * RECIP_100) >> 37 for any 32-bit x
	localparam logic [30:0] RECIP_100 = 31'h51EB_851F;

	localparam logic [1:0] CFG_EMA_WEIGHT = 2'd0;
	localparam logic [1:0] CFG_SAFETY_DIV = 2'd1;
	localparam logic [1:0] CFG_WARMUP = 2'd2;
	localparam logic [1:0] CFG_DEFAULT_PRED = 2'd3;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// one table entry as stored in memory
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] prediction;
		logic [31:0] largest;
		logic [31:0] smallest;
		logic [63:0] byte_sum;
		logic [31:0] samples;
		logic [31:0] overflows;
		logic trained;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic action;
		logic [63:0] route_key;
		logic [31:0] used_bytes;
		logic overflowed;
	} in_word_t;

	typedef struct packed {
		logic [31:0] prediction;
		logic [1:0] status;
		logic trained;
		logic [31:0] sample_total;
		logic [31:0] overflow_total;
		logic [31:0] largest_used;
		logic [31:0] smallest_used;
		logic [63:0] bytes_total;
	} out_word_t;

endpackage

// ===== hw/rtl/route_size_predictor_table.sv =====
// Route size predictor table: one-item-at-a-time search and update over one entry RAM.
// A word scans the stored entries in order, each with a read (SCAN) and a compare (CMP)
// state over the registered RAM read; it ends on a hit, appends after the last entry, or ends on a full-table miss.
// A record then takes four steps for the moving average by 100, then a 33-step headroom
// division. busy drops in the strobe cycle, when the next word may enter.
// Reset clears the entry count and loads the config registers with defaults; entry contents are undefined.
// Results are shown for one cycle on done; the receiver cannot stall.
module route_size_predictor_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input rspt_pkg::in_word_t in_word,
	output logic done,
	output rspt_pkg::out_word_t out_word,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import rspt_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_CMP = 4'd2;
	localparam logic [3:0] S_HAVE = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_REM = 4'd5;
	localparam logic [3:0] S_EMA1 = 4'd6;
	localparam logic [3:0] S_EMA2 = 4'd7;
	localparam logic [3:0] S_DIV = 4'd8;
	localparam logic [3:0] S_WDIV = 4'd9;
	localparam logic [3:0] S_WRITE = 4'd10;

	logic [6:0] ema_weight_q;
	logic [7:0] safety_div_q;
	logic [15:0] warmup_q;
	logic [31:0] default_pred_q;

	logic [3:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic full_q;
	in_word_t item_q;
	entry_t ent_q;
	logic added_q;
	logic [IDX_W-1:0] slot_q;
	logic [25:0] pq_q;
	logic [25:0] uq_q;
	logic [6:0] pr_q;
	logic [6:0] ur_q;
	logic [32:0] base_q;
	logic [13:0] rterm_q;
	logic [32:0] ema_q;

	logic ram_we;
	entry_t ram_wdata;
	entry_t ram_rdata;
	logic div_go;
	logic [32:0] div_dividend;
	logic [31:0] div_divisor;
	logic div_done;
	logic [32:0] div_quot;
	logic [6:0] alpha;
	logic [6:0] beta;
	logic [63:0] pq_prod;
	logic [63:0] uq_prod;
	logic [63:0] rq_prod;
	logic [31:0] pr_full;
	logic [31:0] ur_full;
	logic [32:0] safety_sum;

	rspt_ram #(.WIDTH(ENTRY_W), .DEPTH(ROUTE_ENTRIES)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_q),
		.wdata(ram_wdata),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	rspt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quot)
	);

	assign alpha = (ema_weight_q > PERCENT_FULL) ? PERCENT_FULL : ema_weight_q;
	assign beta = PERCENT_FULL - alpha;
	assign busy = (state_q != S_IDLE);
	assign ram_we = (state_q == S_WRITE);
	assign ram_wdata = ent_q;
	assign div_go = (state_q == S_DIV);
	assign div_dividend = {1'b0, ent_q.largest};
	assign div_divisor = (safety_div_q == 8'd0) ? 32'd1 : {24'd0, safety_div_q};

	// average by 100 split into quotient and remainder parts of both operands
	assign pq_prod = {32'd0, ent_q.prediction} * {33'd0, RECIP_100};
	assign uq_prod = {32'd0, item_q.used_bytes} * {33'd0, RECIP_100};
	assign rq_prod = {50'd0, rterm_q} * {33'd0, RECIP_100};
	assign pr_full = ent_q.prediction - ({6'd0, pq_q} * 32'd100);
	assign ur_full = item_q.used_bytes - ({6'd0, uq_q} * 32'd100);
	assign safety_sum = {1'b0, ent_q.largest} + div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_weight_q <= 7'd20;
			safety_div_q <= 8'd4;
			warmup_q <= 16'd8;
			default_pred_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EMA_WEIGHT: ema_weight_q <= cfg_data[6:0];
				CFG_SAFETY_DIV: safety_div_q <= cfg_data[7:0];
				CFG_WARMUP: warmup_q <= cfg_data[15:0];
				CFG_DEFAULT_PRED: default_pred_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_q <= '0;
			full_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_q <= '0;
						full_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// read issued for scan_q; data valid next cycle
					if (scan_q == count_q) begin
						if (count_q == CNT_W'(ROUTE_ENTRIES)) begin
							full_q <= 1'b1;
							done <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							count_q <= count_q + 1'b1;
							state_q <= S_HAVE;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (ram_rdata.key == item_q.route_key) begin
						state_q <= S_HAVE;
					end else begin
						scan_q <= scan_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_HAVE: state_q <= item_q.action ? S_MUL : S_WRITE;
				S_MUL: state_q <= S_REM;
				S_REM: state_q <= S_EMA1;
				S_EMA1: state_q <= S_EMA2;
				S_EMA2: state_q <= S_DIV;
				S_DIV: state_q <= S_WDIV;
				S_WDIV: if (div_done) state_q <= S_WRITE;
				S_WRITE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) item_q <= in_word;
			S_SCAN: begin
				added_q <= 1'b0;
				slot_q <= scan_q[IDX_W-1:0];
				if (scan_q == count_q) begin
					added_q <= 1'b1;
					ent_q.key <= item_q.route_key;
					ent_q.prediction <= default_pred_q;
					ent_q.largest <= '0;
					ent_q.smallest <= '0;
					ent_q.byte_sum <= '0;
					ent_q.samples <= '0;
					ent_q.overflows <= '0;
					ent_q.trained <= 1'b0;
				end
			end
			S_CMP: ent_q <= ram_rdata;
			S_HAVE: begin
				// statistics update; prediction finished after the division
				if (item_q.action) begin
					ent_q.byte_sum <= ent_q.byte_sum + {32'd0, item_q.used_bytes};
					if (ent_q.samples != MAX32) ent_q.samples <= ent_q.samples + 32'd1;
					if (item_q.used_bytes > ent_q.largest) ent_q.largest <= item_q.used_bytes;
					if (ent_q.smallest == 32'd0 || item_q.used_bytes < ent_q.smallest)
						ent_q.smallest <= item_q.used_bytes;
					if (((ent_q.samples != MAX32) ? ent_q.samples + 32'd1 : ent_q.samples)
						>= {16'd0, warmup_q})
						ent_q.trained <= 1'b1;
					if (item_q.overflowed && ent_q.overflows != MAX32)
						ent_q.overflows <= ent_q.overflows + 32'd1;
				end
			end
			S_MUL: begin
				pq_q <= pq_prod[62:37];
				uq_q <= uq_prod[62:37];
			end
			S_REM: begin
				pr_q <= pr_full[6:0];
				ur_q <= ur_full[6:0];
			end
			S_EMA1: begin
				base_q <= ({7'd0, pq_q} * {26'd0, beta}) + ({7'd0, uq_q} * {26'd0, alpha});
				rterm_q <= ({7'd0, pr_q} * {7'd0, beta}) + ({7'd0, ur_q} * {7'd0, alpha});
			end
			S_EMA2: ema_q <= base_q + {26'd0, rq_prod[43:37]};
			S_WDIV: if (div_done) begin
				if (ema_q < safety_sum) begin
					ent_q.prediction <= safety_sum[32] ? MAX32 : safety_sum[31:0];
				end else begin
					ent_q.prediction <= ema_q[32] ? MAX32 : ema_q[31:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		out_word = '0;
		if (full_q) begin
			out_word.status = ST_FULL;
			out_word.prediction = default_pred_q;
			if (!item_q.action && default_pred_q < MIN_PREDICTION)
				out_word.prediction = MIN_PREDICTION;
		end else begin
			out_word.prediction = ent_q.prediction;
			if (!item_q.action && ent_q.prediction < MIN_PREDICTION)
				out_word.prediction = MIN_PREDICTION;
			out_word.status = added_q ? ST_ADDED : ST_FOUND;
			out_word.trained = ent_q.trained;
			out_word.sample_total = ent_q.samples;
			out_word.overflow_total = ent_q.overflows;
			out_word.largest_used = ent_q.largest;
			out_word.smallest_used = ent_q.smallest;
			out_word.bytes_total = ent_q.byte_sum;
		end
	end

	// keep outputs stable between cycles: register the strobe's payload
	// (done is registered; out_word is decoded from registers held until the next start or a config write)

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ROUTE_ENTRIES))
		else $error("entry count beyond table");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= count_q)
		else $error("scan beyond entry count");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> done)
		else $error("entry write without result");
endmodule

// ===== hw/rtl/rspt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rspt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/rspt_div.sv =====
// Restoring divider, one quotient bit a cycle (33-bit dividend).
module rspt_div (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [32:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [32:0] quotient
);
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[32]} - {2'b0, divisor};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end
endmodule

// ===== tb/route_size_predictor_table_tb.sv =====
// Testbench for the route size predictor table: scoreboard class plus driving tasks.
`timescale 1ns / 1ps

module route_size_predictor_table_tb;
	import rspt_pkg::*;

	class size_scoreboard;
		logic [6:0] weight;
		logic [7:0] divisor;
		logic [15:0] warmup;
		logic [31:0] dflt;
		int count;
		entry_t tbl [ROUTE_ENTRIES];
		out_word_t pending [$];
		int errors;
		int checked;

		function void clear();
			weight = 7'd20;
			divisor = 8'd4;
			warmup = 16'd8;
			dflt = 32'd65536;
			count = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CFG_EMA_WEIGHT: weight = val[6:0];
				CFG_SAFETY_DIV: divisor = val[7:0];
				CFG_WARMUP: warmup = val[15:0];
				CFG_DEFAULT_PRED: dflt = val;
				default: ;
			endcase
		endfunction

		function void note_word(in_word_t w);
			int s;
			bit added;
			out_word_t r;
			logic [31:0] alpha, dv;
			logic [63:0] ema, safety;
			s = -1;
			added = 0;
			r = '0;
			for (int i = 0; i < count; i++)
				if (s < 0 && tbl[i].key == w.route_key) s = i;
			if (s < 0 && count < ROUTE_ENTRIES) begin
				s = count;
				count++;
				tbl[s] = '0;
				tbl[s].key = w.route_key;
				tbl[s].prediction = dflt;
				added = 1;
			end
			if (s < 0) begin
				r.prediction = dflt;
				if (!w.action && dflt < MIN_PREDICTION) r.prediction = MIN_PREDICTION;
				r.status = ST_FULL;
				pending.push_back(r);
				return;
			end
			if (w.action) begin
				alpha = (weight > 100) ? 32'd100 : 32'(weight);
				dv = (divisor == 0) ? 32'd1 : 32'(divisor);
				tbl[s].byte_sum += 64'(w.used_bytes);
				if (tbl[s].samples != MAX32) tbl[s].samples++;
				if (w.used_bytes > tbl[s].largest) tbl[s].largest = w.used_bytes;
				if (tbl[s].smallest == 0 || w.used_bytes < tbl[s].smallest)
					tbl[s].smallest = w.used_bytes;
				if (tbl[s].samples >= 32'(warmup)) tbl[s].trained = 1;
				ema = (64'(tbl[s].prediction) * (100 - alpha) + 64'(w.used_bytes) * alpha) / 100;
				safety = 64'(tbl[s].largest) + 64'(tbl[s].largest / dv);
				if (ema < safety) ema = safety;
				if (ema > 64'(MAX32)) ema = 64'(MAX32);
				tbl[s].prediction = ema[31:0];
				if (w.overflowed && tbl[s].overflows != MAX32) tbl[s].overflows++;
			end
			r.prediction = tbl[s].prediction;
			if (!w.action && r.prediction < MIN_PREDICTION) r.prediction = MIN_PREDICTION;
			r.status = added ? ST_ADDED : ST_FOUND;
			r.trained = tbl[s].trained;
			r.sample_total = tbl[s].samples;
			r.overflow_total = tbl[s].overflows;
			r.largest_used = tbl[s].largest;
			r.smallest_used = tbl[s].smallest;
			r.bytes_total = tbl[s].byte_sum;
			pending.push_back(r);
		endfunction

		function void check_word(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected word %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.prediction !== e.prediction)
				$display("%0t prediction exp %h got %h", $time, e.prediction, got.prediction);
			if (got.status !== e.status)
				$display("%0t status exp %h got %h", $time, e.status, got.status);
			if (got.trained !== e.trained)
				$display("%0t trained exp %h got %h", $time, e.trained, got.trained);
			if (got.sample_total !== e.sample_total)
				$display("%0t samples exp %h got %h", $time, e.sample_total, got.sample_total);
			if (got.overflow_total !== e.overflow_total)
				$display("%0t overflows exp %h got %h", $time, e.overflow_total,
					got.overflow_total);
			if (got.largest_used !== e.largest_used)
				$display("%0t largest exp %h got %h", $time, e.largest_used, got.largest_used);
			if (got.smallest_used !== e.smallest_used)
				$display("%0t smallest exp %h got %h", $time, e.smallest_used,
					got.smallest_used);
			if (got.bytes_total !== e.bytes_total)
				$display("%0t bytes exp %h got %h", $time, e.bytes_total, got.bytes_total);
			if (got !== e) errors++;
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, cfg_we;
	in_word_t in_word;
	out_word_t out_word;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	size_scoreboard sb;
	bit calm;
	int idle_cycles;
	int items;

	route_size_predictor_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .out_word(out_word), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (done) sb.check_word(out_word);
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("route_size_predictor_table_tb: errors");
			$finish;
		end
	end

	task automatic send_word(in_word_t w);
		if (!calm && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 15)) @(posedge clk);
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
		items++;
		start <= 1'b0;
		// the block stays busy after acceptance until the word is done
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic in_word_t make_word(logic act, logic [63:0] k, logic [31:0] u,
		logic ov);
		in_word_t w;
		w.action = act;
		w.route_key = k;
		w.used_bytes = u;
		w.overflowed = ov;
		return w;
	endfunction

	function automatic logic [31:0] rand_used();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: return $urandom_range(0, 8);
			2: return $urandom_range(0, 5000);
			default: return $urandom;
		endcase
	endfunction

	// Random phase over a key pool; pool sizes above 64 push the table to full.
	task automatic random_phase(int n, int pool);
		logic [63:0] base;
		base = {$urandom, $urandom};
		repeat (n) begin
			logic [63:0] k;
			if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
			else k = base ^ 64'($urandom_range(0, pool - 1));
			send_word(make_word($urandom_range(0, 3) != 0, k, rand_used(), 1'($urandom)));
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_EMA_WEIGHT;
		cfg_data = '0;
		calm = 0;
		idle_cycles = 0;
		items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: new entry, extremes, saturation, counters
		send_word(make_word(1'b0, 64'h0, 32'h0, 1'b0));
		send_word(make_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_word(make_word(1'b1, 64'h0, 32'h0, 1'b1));
		send_word(make_word(1'b1, 64'h0, 32'hFFFF_FFFF, 1'b1));
		send_word(make_word(1'b1, 64'h0, 32'd10, 1'b0));
		send_word(make_word(1'b0, 64'h0, 32'h0, 1'b0));
		send_word(make_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd100, 1'b1));
		drain();
		write_reg(CFG_EMA_WEIGHT, 32'd127);
		write_reg(CFG_SAFETY_DIV, 32'd0);
		write_reg(CFG_WARMUP, 32'd0);
		write_reg(CFG_DEFAULT_PRED, 32'd100);
		send_word(make_word(1'b0, 64'h5, 32'd0, 1'b0));
		send_word(make_word(1'b1, 64'h6, 32'd50, 1'b0));
		send_word(make_word(1'b1, 64'h5, 32'd0, 1'b0));
		// fill the table, then misses on a full table
		for (int i = 0; i < 62; i++) send_word(make_word(i[0], 64'h1000 + i, i, 1'b1));
		send_word(make_word(1'b0, 64'hDEAD, 32'd1, 1'b0));
		send_word(make_word(1'b1, 64'hBEEF, 32'd1, 1'b1));
		send_word(make_word(1'b0, 64'h1000 + 61, 32'd0, 1'b0));
		drain();

		// random phases over several settings; reset empties the table only at start and the
		// directed phase has filled it, so each key is found or meets a full table
		write_reg(CFG_EMA_WEIGHT, 32'd0);
		write_reg(CFG_SAFETY_DIV, 32'd255);
		write_reg(CFG_WARMUP, 32'd65535);
		write_reg(CFG_DEFAULT_PRED, 32'hFFFF_FFFF);
		random_phase(400, 80);
		drain();
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_EMA_WEIGHT, $urandom_range(0, 127));
			write_reg(CFG_SAFETY_DIV, $urandom_range(0, 255));
			write_reg(CFG_WARMUP, $urandom_range(0, 12));
			write_reg(CFG_DEFAULT_PRED, $urandom);
			random_phase(350, 70);
			drain();
		end
		write_reg(CFG_EMA_WEIGHT, 32'd100);
		write_reg(CFG_SAFETY_DIV, 32'd1);
		calm = 1;
		random_phase(300, 70);
		drain();

		$display("run covered %0d words, %0d results checked, table held %0d entries",
			items, sb.checked, sb.count);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("route_size_predictor_table_tb: clean");
		else
			$display("route_size_predictor_table_tb: errors");
		$finish;
	end
endmodule
